FILE: hdl/tccw_pkg.sv
`timescale 1ns / 1ps
package tccw_pkg;

    localparam int COLUMNS    = 80;
    localparam int LINES      = 25;
    localparam int CELL_COUNT = COLUMNS * LINES;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int COL_W      = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int ROW_W      = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int CELL_W     = 16;
    localparam int OUT_COL_W  = 7;
    localparam int OUT_ROW_W  = 5;
    localparam int CFG_IDX_W  = 8;
    localparam int COLOR_W    = 4;

    localparam int SCROLL_END = CELL_COUNT - COLUMNS;

    localparam logic [7:0]        CH_BLANK   = 8'h20;
    localparam logic [7:0]        CH_NL      = 8'h0A;
    localparam logic [CELL_W-1:0] RESET_CELL = 16'h0720;

    localparam logic [1:0] CMD_PUT_CUR = 2'd0;
    localparam logic [1:0] CMD_PUT_AT  = 2'd1;
    localparam logic [1:0] CMD_CLEAR   = 2'd2;
    localparam logic [1:0] CMD_READ    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_FG = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BG = 8'd1;

    localparam logic [COLOR_W-1:0] FG_RESET = 4'd7;
    localparam logic [COLOR_W-1:0] BG_RESET = 4'd0;

    typedef struct packed {
        logic                we;
        logic [ADDR_W-1:0]   waddr;
        logic [CELL_W-1:0]   wdata;
        logic                re;
        logic [ADDR_W-1:0]   raddr;
    } t_mem_req;

    typedef struct packed {
        logic [OUT_ROW_W-1:0] row;
        logic [OUT_COL_W-1:0] col;
        logic [CELL_W-1:0]    cell_value;
    } t_result;

endpackage

FILE: hdl/tccw_screen.sv
`timescale 1ns / 1ps
module tccw_screen (
    input  logic                       i_clk,
    input  tccw_pkg::t_mem_req         i_req,
    output logic [tccw_pkg::CELL_W-1:0] o_rdata
);
    import tccw_pkg::*;

    logic [CELL_W-1:0] r_mem [CELL_COUNT];
    logic [CELL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/tccw_ctrl.sv
`timescale 1ns / 1ps
module tccw_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [1:0]                  i_cmd,
    input  logic [7:0]                  i_ch,
    input  logic [7:0]                  i_tcol,
    input  logic [7:0]                  i_trow,
    input  logic [7:0]                  i_attr,
    output tccw_pkg::t_mem_req          o_req,
    input  logic [tccw_pkg::CELL_W-1:0] i_rdata,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output tccw_pkg::t_result           o_res
);
    import tccw_pkg::*;

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_POINT = 3'd2;
    localparam logic [2:0] S_RDATA = 3'd3;
    localparam logic [2:0] S_SC_RD = 3'd4;
    localparam logic [2:0] S_SC_WR = 3'd5;
    localparam logic [2:0] S_FILL  = 3'd6;

    logic [2:0]        r_state,    n_state;
    logic [ADDR_W-1:0] r_addr,     n_addr;
    logic [COL_W-1:0]  r_col,      n_col;
    logic [ROW_W-1:0]  r_row,      n_row;
    logic [ADDR_W-1:0] r_row_base, n_row_base;
    logic [ADDR_W-1:0] r_cur_addr, n_cur_addr;
    logic [1:0]        r_cmd,      n_cmd;
    logic [7:0]        r_ch,       n_ch;
    logic              r_inr,      n_inr;
    logic              r_out_valid, n_out_valid;
    t_result           r_res,      n_res;

    logic              accept;
    logic              last_col;
    logic              last_row;
    logic [15:0]       lin;
    logic              in_range;
    logic [ADDR_W-1:0] addr_inc;
    logic              load_res;
    logic [CELL_W-1:0] res_value;
    logic [CELL_W-1:0] blank;
    logic [COL_W+OUT_COL_W-1:0] col_ext;
    logic [ROW_W+OUT_ROW_W-1:0] row_ext;

    assign o_s_tready = (r_state == S_IDLE) && (!r_out_valid || i_m_tready);
    assign accept     = i_s_tvalid && o_s_tready;
    assign last_col   = (r_col == COL_W'(COLUMNS - 1));
    assign last_row   = (r_row == ROW_W'(LINES - 1));
    assign lin        = 16'(i_trow) * 16'(COLUMNS) + 16'(i_tcol);
    assign in_range   = (16'(i_tcol) < 16'(COLUMNS)) && (16'(i_trow) < 16'(LINES));
    assign addr_inc   = r_addr + ADDR_W'(1);
    assign blank      = {i_attr, CH_BLANK};

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_col       = r_col;
        n_row       = r_row;
        n_row_base  = r_row_base;
        n_cur_addr  = r_cur_addr;
        n_cmd       = r_cmd;
        n_ch        = r_ch;
        n_inr       = r_inr;
        n_out_valid = r_out_valid && !i_m_tready;
        n_res       = r_res;
        load_res    = 1'b0;
        res_value   = '0;
        o_req       = '0;

        unique case (r_state)
            S_INIT: begin
                o_req.we    = 1'b1;
                o_req.waddr = r_addr;
                o_req.wdata = RESET_CELL;
                n_addr      = addr_inc;
                if (r_addr == ADDR_W'(CELL_COUNT - 1)) begin
                    n_addr  = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_cmd = i_cmd;
                    n_ch  = i_ch;
                    n_inr = in_range;
                    unique case (i_cmd)
                        CMD_PUT_CUR: begin
                            if (i_ch != CH_NL) begin
                                o_req.we    = 1'b1;
                                o_req.waddr = r_cur_addr;
                                o_req.wdata = {i_attr, i_ch};
                            end
                            if (i_ch != CH_NL && !last_col) begin
                                n_col      = r_col + COL_W'(1);
                                n_cur_addr = r_cur_addr + ADDR_W'(1);
                                load_res   = 1'b1;
                            end else if (!last_row) begin
                                n_col      = '0;
                                n_row      = r_row + ROW_W'(1);
                                n_row_base = r_row_base + ADDR_W'(COLUMNS);
                                n_cur_addr = r_row_base + ADDR_W'(COLUMNS);
                                load_res   = 1'b1;
                            end else begin
                                n_col      = '0;
                                n_cur_addr = r_row_base;
                                n_addr     = '0;
                                n_state    = S_SC_RD;
                            end
                        end
                        CMD_PUT_AT, CMD_READ: begin
                            n_addr  = lin[ADDR_W-1:0];
                            n_state = S_POINT;
                        end
                        CMD_CLEAR: begin
                            n_col      = '0;
                            n_row      = '0;
                            n_row_base = '0;
                            n_cur_addr = '0;
                            n_addr     = '0;
                            n_state    = S_FILL;
                        end
                        default: ;
                    endcase
                end
            end
            S_POINT: begin
                if (r_cmd == CMD_READ && r_inr) begin
                    o_req.re    = 1'b1;
                    o_req.raddr = r_addr;
                    n_state     = S_RDATA;
                end else begin
                    if (r_cmd == CMD_PUT_AT && r_inr) begin
                        o_req.we    = 1'b1;
                        o_req.waddr = r_addr;
                        o_req.wdata = {i_attr, r_ch};
                    end
                    load_res = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_RDATA: begin
                res_value = i_rdata;
                load_res  = 1'b1;
                n_state   = S_IDLE;
            end
            S_SC_RD: begin
                o_req.re    = 1'b1;
                o_req.raddr = r_addr + ADDR_W'(COLUMNS);
                n_state     = S_SC_WR;
            end
            S_SC_WR: begin
                o_req.we    = 1'b1;
                o_req.waddr = r_addr;
                o_req.wdata = i_rdata;
                n_addr      = addr_inc;
                if (r_addr == ADDR_W'(SCROLL_END - 1)) begin
                    n_state = S_FILL;
                end else begin
                    n_state = S_SC_RD;
                end
            end
            S_FILL: begin
                o_req.we    = 1'b1;
                o_req.waddr = r_addr;
                o_req.wdata = blank;
                n_addr      = addr_inc;
                if (r_addr == ADDR_W'(CELL_COUNT - 1)) begin
                    load_res = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
                n_addr  = '0;
            end
        endcase

        col_ext = {{OUT_COL_W{1'b0}}, n_col};
        row_ext = {{OUT_ROW_W{1'b0}}, n_row};
        if (load_res) begin
            n_out_valid      = 1'b1;
            n_res.cell_value = res_value;
            n_res.col        = col_ext[OUT_COL_W-1:0];
            n_res.row        = row_ext[OUT_ROW_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_addr      <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_row_base  <= '0;
            r_cur_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_col       <= n_col;
            r_row       <= n_row;
            r_row_base  <= n_row_base;
            r_cur_addr  <= n_cur_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_ch  <= n_ch;
        r_inr <= n_inr;
        r_res <= n_res;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_res      = r_res;

endmodule

FILE: hdl/text_console_cell_writer.sv
`timescale 1ns / 1ps
// Put at cursor: result registered at the accepting edge unless the screen scrolls.
// Put/read at position: address multiply on accept, then one screen memory access in S_POINT;
// a read returns its cell through S_RDATA. Clear fills every cell with blanks in S_FILL.
// Scroll copies each row up via alternating S_SC_RD/S_SC_WR states, then blanks the last row.
// Reset (sync, active low) runs a pass writing 0x0720 to every cell, with o_s_tready low;
// colors return to fg 7 / bg 0 and the cursor to 0,0.
module text_console_cell_writer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [23:0]                    i_s_tdata,   // character, target_col, target_row
    input  logic [1:0]                     i_s_tuser,   // cmd
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [31:0]                    o_m_tdata,   // cell_value, cursor_col, cursor_row
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tccw_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tccw_pkg::COLOR_W-1:0]   i_cfg_data
);
    import tccw_pkg::*;

    logic [COLOR_W-1:0] r_fg;
    logic [COLOR_W-1:0] r_bg;
    t_mem_req           mem_req;
    logic [CELL_W-1:0]  mem_rdata;
    t_result            res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg <= FG_RESET;
            r_bg <= BG_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == REG_FG) begin
                r_fg <= i_cfg_data;
            end else if (i_cfg_index == REG_BG) begin
                r_bg <= i_cfg_data;
            end
        end
    end

    tccw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_cmd      (i_s_tuser),
        .i_ch       (i_s_tdata[7:0]),
        .i_tcol     (i_s_tdata[15:8]),
        .i_trow     (i_s_tdata[23:16]),
        .i_attr     ({r_bg, r_fg}),
        .o_req      (mem_req),
        .i_rdata    (mem_rdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_res      (res)
    );

    tccw_screen u_screen (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    assign o_m_tdata = {4'b0, res};

    a_accept_busy_or_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (o_m_tvalid || !o_s_tready))
        else $error("accepted transaction neither completed nor holding the block busy");

    a_cursor_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ((32'(o_m_tdata[22:16]) < COLUMNS) && (32'(o_m_tdata[27:23]) < LINES)))
        else $error("cursor outside the screen");

endmodule
